// ===== rtl/core/ps2mc_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet cursor block.
package ps2mc_pkg;

  // Default position width and field widths.
  localparam int unsigned POS_BITS_DEF = 12;
  localparam int unsigned LIM_BITS     = 12;
  localparam int unsigned CURSOR_BITS  = 12;
  localparam int unsigned BYTE_BITS    = 8;

  // Reset values of the screen limits.
  localparam logic [LIM_BITS-1:0] DEF_WIDTH  = LIM_BITS'(320);
  localparam logic [LIM_BITS-1:0] DEF_HEIGHT = LIM_BITS'(200);

  // Configuration port geometry.
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  // Register indexes.
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  // Position of the next byte within a three-byte packet.
  typedef enum logic [1:0] {
    PH_FLAGS = 2'd0,
    PH_DX    = 2'd1,
    PH_DY    = 2'd2
  } phase_e;

  // Screen limits handed from the register block to the tracker.
  typedef struct packed {
    logic [LIM_BITS-1:0] width;
    logic [LIM_BITS-1:0] height;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [CURSOR_BITS-1:0] cursor_x;
    logic [CURSOR_BITS-1:0] cursor_y;
    logic                   button_left;
    logic                   button_right;
    logic                   button_middle;
    logic                   packet_done;
  } res_t;

endpackage

// ===== rtl/core/ps2mc_cfg_regs.sv =====
// Configuration registers for the screen limits, written over the register port.
module ps2mc_cfg_regs import ps2mc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_WIDTH:  cfg_d.width  = pwdata[LIM_BITS-1:0];
        REG_HEIGHT: cfg_d.height = pwdata[LIM_BITS-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= DEF_WIDTH;
      cfg_q.height <= DEF_HEIGHT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = APB_DATA_BITS'(cfg_q.width);
      REG_HEIGHT: prdata = APB_DATA_BITS'(cfg_q.height);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/ps2mc_axis_clamp.sv =====
// Adds a 9-bit signed delta to one cursor axis and clamps it to the screen limit.
module ps2mc_axis_clamp import ps2mc_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic [POS_BITS-1:0]  pos_i,
  input  logic                 sign_i,
  input  logic [BYTE_BITS-1:0] low_i,
  input  logic [LIM_BITS-1:0]  limit_i,
  output logic [POS_BITS-1:0]  pos_o
);

  localparam int unsigned WideBits = ((POS_BITS > LIM_BITS) ? POS_BITS : LIM_BITS) + 2;
  localparam logic signed [WideBits-1:0] Cap = WideBits'(2 ** POS_BITS);

  logic signed [WideBits-1:0] delta, sum, lim_in, lim, lim_m1, clamped;

  always_comb begin
    delta   = WideBits'(signed'({sign_i, low_i}));
    sum     = signed'(WideBits'(pos_i)) + delta;
    lim_in  = signed'(WideBits'(limit_i));
    // The limit is capped so the position always fits the register.
    lim     = (lim_in > Cap) ? Cap : lim_in;
    lim_m1  = lim - signed'(WideBits'(1));
    clamped = (sum >= lim) ? lim_m1 : sum;
    // A zero limit makes the upper clamp negative; the lower clamp then wins.
    pos_o   = clamped[WideBits-1] ? '0 : clamped[POS_BITS-1:0];
  end

endmodule

// ===== rtl/core/ps2mc_tracker.sv =====
// Input register, packet state, cursor update and result register.
module ps2mc_tracker import ps2mc_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  input  logic [BYTE_BITS-1:0] in_byte_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output res_t                 res_o
);

  localparam logic [POS_BITS-1:0] PosXRst = POS_BITS'(DEF_WIDTH / 2);
  localparam logic [POS_BITS-1:0] PosYRst = POS_BITS'(DEF_HEIGHT / 2);

  logic                 in_valid_q, in_valid_d;
  logic [BYTE_BITS-1:0] in_byte_q;
  logic                 out_valid_q, out_valid_d;
  res_t                 res_q, res_d;

  logic                 skip_q, skip_d;
  phase_e               phase_q, phase_d;
  logic                 sign_x_q, sign_x_d, sign_y_q, sign_y_d;
  logic [POS_BITS-1:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [2:0]           btn_q, btn_d;
  logic                 done;

  logic                 fire_in, out_free, step;
  logic [POS_BITS-1:0]  new_x, new_y;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || out_free;
  assign fire_in    = in_valid_i && in_ready_o;
  assign step       = in_valid_q && out_free;

  ps2mc_axis_clamp #(.POS_BITS(POS_BITS)) u_clamp_x (
    .pos_i   (pos_x_q),
    .sign_i  (sign_x_q),
    .low_i   (in_byte_q),
    .limit_i (cfg_i.width),
    .pos_o   (new_x)
  );

  ps2mc_axis_clamp #(.POS_BITS(POS_BITS)) u_clamp_y (
    .pos_i   (pos_y_q),
    .sign_i  (sign_y_q),
    .low_i   (in_byte_q),
    .limit_i (cfg_i.height),
    .pos_o   (new_y)
  );

  always_comb begin
    skip_d   = skip_q;
    phase_d  = phase_q;
    sign_x_d = sign_x_q;
    sign_y_d = sign_y_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    btn_d    = btn_q;
    done     = 1'b0;
    if (step) begin
      if (skip_q) begin
        // The first byte after reset is dropped.
        skip_d = 1'b0;
      end else begin
        unique case (phase_q)
          PH_DX: begin
            pos_x_d = new_x;
            phase_d = PH_DY;
          end
          PH_DY: begin
            pos_y_d = new_y;
            phase_d = PH_FLAGS;
            done    = 1'b1;
          end
          default: begin
            btn_d    = in_byte_q[2:0];
            sign_x_d = in_byte_q[4];
            sign_y_d = in_byte_q[5];
            phase_d  = PH_DX;
          end
        endcase
      end
    end

    res_d.cursor_x      = CURSOR_BITS'(pos_x_d);
    res_d.cursor_y      = CURSOR_BITS'(pos_y_d);
    res_d.button_left   = btn_d[0];
    res_d.button_right  = btn_d[1];
    res_d.button_middle = btn_d[2];
    res_d.packet_done   = done;

    if (fire_in) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end

    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      skip_q      <= 1'b1;
      phase_q     <= PH_FLAGS;
      sign_x_q    <= 1'b0;
      sign_y_q    <= 1'b0;
      pos_x_q     <= PosXRst;
      pos_y_q     <= PosYRst;
      btn_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      skip_q      <= skip_d;
      phase_q     <= phase_d;
      sign_x_q    <= sign_x_d;
      sign_y_q    <= sign_y_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      btn_q       <= btn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_in) begin
      in_byte_q <= in_byte_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // Once the first byte has been dropped, dropping never resumes.
  a_skip_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skip_q |=> !skip_q)
    else $error("skip flag set again after the first byte");

  // A Y delta byte always produces a packet-complete result.
  a_done_on_dy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !skip_q && (phase_q == PH_DY) |=> out_valid_q && res_q.packet_done)
    else $error("Y delta byte did not complete a packet");

  // A held input byte is not lost or overwritten while the result side stalls.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_byte_q))
    else $error("input byte lost during stall");

  // No packet completes while the first byte is still being dropped.
  a_no_done_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && skip_q |=> !res_q.packet_done)
    else $error("packet marked complete on the dropped byte");

endmodule

// ===== rtl/core/ps2_mouse_packet_cursor_top.sv =====
// Top level of the PS/2 mouse packet decoder with a clamped screen cursor.
//
// This block takes the bytes received from a PS/2 mouse, one request per
// byte on the input stream, and returns one request per byte on the output
// stream. The first byte after reset is dropped (it still produces a result
// carrying the reset cursor). The following bytes form three-byte packets:
// a flags byte that sets the left, right and middle buttons and latches the
// X and Y sign bits, then a 9-bit signed X delta, then a 9-bit signed Y delta.
// Each delta moves the cursor, which is clamped to 0 and to one less than the
// configured horizontal or vertical screen limit (and to the POS_BITS position
// range); a limit of zero parks that axis at 0. The sync bit, the overflow
// bits and Y inversion are ignored. Output tlast marks the byte that completed
// a packet. Each byte passes through an input register and then the result
// register, and a new byte is accepted every cycle while the output is not
// stalled; the cursor update is a single add-and-clamp per axis between those
// registers. The result register is held while the output stalls or no byte
// waits, and the input register keeps accepting while the result can move on.
// Screen limits are written at byte addresses 0 (width) and 4 (height) and
// take effect at the next delta on that axis; write them only while the block
// is idle.
module ps2_mouse_packet_cursor_top import ps2mc_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Input stream.
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] rx_byte
  // Output stream.
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [11:0] cursor_x, [23:12] cursor_y, [24] button_left,
  // [25] button_right, [26] button_middle, [31:27] zero
  output logic [31:0]              m_axis_tdata,
  output logic                     m_axis_tlast,   // packet_done
  // Register port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  cfg_t cfg;
  res_t res;

  ps2mc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ps2mc_tracker #(.POS_BITS(POS_BITS)) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result fields from the lowest bit up, zero-filled to 32 bits.
  assign m_axis_tdata = {5'b0, res.button_middle, res.button_right, res.button_left,
                         res.cursor_y, res.cursor_x};
  assign m_axis_tlast = res.packet_done;

endmodule

// ===== bench/ps2_mouse_packet_cursor_checker.sv =====
// Checker that predicts the cursor results of the PS/2 mouse packet block and compares them.
module ps2_mouse_packet_cursor_checker import ps2mc_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     byte_valid_i,
  input  logic                     byte_ready_i,
  input  logic [7:0]               byte_data_i,
  input  logic                     res_valid_i,
  input  logic                     res_ready_i,
  input  logic [31:0]              res_data_i,
  input  logic                     res_last_i,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic                     pready_i,
  input  logic [APB_ADDR_BITS-1:0] paddr_i,
  input  logic [APB_DATA_BITS-1:0] pwdata_i,
  output int unsigned              mismatches_o,
  output int unsigned              awaited_o
);

  logic [LIM_BITS-1:0]    width_q;
  logic [LIM_BITS-1:0]    height_q;
  logic                   drop_first;
  phase_e                 phase;
  logic                   neg_x;
  logic                   neg_y;
  logic [CURSOR_BITS-1:0] cur_x;
  logic [CURSOR_BITS-1:0] cur_y;
  logic [2:0]             btn;
  res_t                   cursor_q [$];
  int unsigned            mism = 0;

  assign mismatches_o = mism;

  // Applies a 9-bit signed delta and clamps to 0..limit-1, the limit capped at 2^POS_BITS.
  function automatic logic [CURSOR_BITS-1:0] step_axis(input logic [CURSOR_BITS-1:0] pos,
                                                       input logic neg,
                                                       input logic [7:0] mag,
                                                       input logic [LIM_BITS-1:0] limit);
    longint lim;
    longint p;
    lim = longint'(limit);
    if (lim > (longint'(1) << POS_BITS)) lim = longint'(1) << POS_BITS;
    p = longint'(pos) + longint'(mag) - (neg ? 256 : 0);
    if (p >= lim) p = lim - 1;
    if (p < 0) p = 0;
    return p[CURSOR_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mism < 100) begin
      $display("mismatch at %0t: %s is %0d, expected %0d", $time, what, got, want);
    end
    mism++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    res_t got;
    res_t want;
    logic done;
    if (!rst_ni) begin
      width_q    = DEF_WIDTH;
      height_q   = DEF_HEIGHT;
      drop_first = 1'b1;
      phase      = PH_FLAGS;
      neg_x      = 1'b0;
      neg_y      = 1'b0;
      cur_x      = DEF_WIDTH >> 1;
      cur_y      = DEF_HEIGHT >> 1;
      btn        = 3'b000;
      cursor_q.delete();
    end else begin
      // A result leaving now always belongs to an older byte, so compare before predicting.
      if (res_valid_i && res_ready_i) begin
        got.cursor_x      = res_data_i[11:0];
        got.cursor_y      = res_data_i[23:12];
        got.button_left   = res_data_i[24];
        got.button_right  = res_data_i[25];
        got.button_middle = res_data_i[26];
        got.packet_done   = res_last_i;
        if (cursor_q.size() == 0) begin
          report_mismatch("result with nothing awaited, cursor_x", 32'(got.cursor_x), 0);
        end else begin
          want = cursor_q.pop_front();
          if (got.cursor_x != want.cursor_x)
            report_mismatch("cursor_x", 32'(got.cursor_x), 32'(want.cursor_x));
          if (got.cursor_y != want.cursor_y)
            report_mismatch("cursor_y", 32'(got.cursor_y), 32'(want.cursor_y));
          if (got.button_left != want.button_left)
            report_mismatch("button_left", 32'(got.button_left), 32'(want.button_left));
          if (got.button_right != want.button_right)
            report_mismatch("button_right", 32'(got.button_right), 32'(want.button_right));
          if (got.button_middle != want.button_middle)
            report_mismatch("button_middle", 32'(got.button_middle),
                            32'(want.button_middle));
          if (got.packet_done != want.packet_done)
            report_mismatch("packet_done", 32'(got.packet_done), 32'(want.packet_done));
          if (res_data_i[31:27] != 5'd0)
            report_mismatch("tdata padding", 32'(res_data_i[31:27]), 0);
        end
      end

      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[2]))
          REG_WIDTH:  width_q  = pwdata_i[LIM_BITS-1:0];
          default:    height_q = pwdata_i[LIM_BITS-1:0];
        endcase
      end

      if (byte_valid_i && byte_ready_i) begin
        done = 1'b0;
        if (drop_first) begin
          drop_first = 1'b0;
        end else begin
          case (phase)
            PH_DX: begin
              cur_x = step_axis(cur_x, neg_x, byte_data_i, width_q);
              phase = PH_DY;
            end
            PH_DY: begin
              cur_y = step_axis(cur_y, neg_y, byte_data_i, height_q);
              phase = PH_FLAGS;
              done  = 1'b1;
            end
            default: begin
              btn   = byte_data_i[2:0];
              neg_x = byte_data_i[4];
              neg_y = byte_data_i[5];
              phase = PH_DX;
            end
          endcase
        end
        want.cursor_x      = cur_x;
        want.cursor_y      = cur_y;
        want.button_left   = btn[0];
        want.button_right  = btn[1];
        want.button_middle = btn[2];
        want.packet_done   = done;
        cursor_q.push_back(want);
      end
    end
    awaited_o = cursor_q.size();
  end

endmodule

// ===== bench/tb_ps2_mouse_packet_cursor_top.sv =====
// Testbench top for the PS/2 mouse packet cursor block: stimulus, stalls and verdict.
module tb_ps2_mouse_packet_cursor_top;
  import ps2mc_pkg::*;

  // Cycles without any accepted request before the run is declared hung. The longest
  // legal quiet stretch is a sender gap or a receiver stall.
  localparam int unsigned QUIET_LIMIT  = 4000;
  // Marker in the limit table for a limit drawn at random.
  localparam int unsigned RANDOM_LIMIT = 32'hFFFF;
  localparam int unsigned NUM_PHASES   = 11;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata = 8'h00;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [31:0]              m_axis_tdata;
  logic                     m_axis_tlast;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  int unsigned mismatches;
  int unsigned awaited;

  // Sender burst bookkeeping: requests left in the current burst, and whether the
  // current phase sends back to back with no gaps at all.
  int unsigned burst_left = 0;
  logic        sender_steady = 1'b0;

  // Receiver stall pattern: a mode held for a random number of cycles.
  int unsigned sink_mode = 0;
  int unsigned sink_mode_left = 0;
  int unsigned sink_tick = 0;

  int unsigned quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ps2_mouse_packet_cursor_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // The checker watches both streams and the register port on its own; this module
  // only reads back how many mismatches it saw and how many results it still awaits.
  ps2_mouse_packet_cursor_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_i (s_axis_tready),
    .byte_data_i  (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_last_i   (m_axis_tlast),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .awaited_o    (awaited)
  );

  // The receiver switches between always ready, coin-flip ready, a fixed one-in-four
  // pattern and long stalls, so back pressure lands on every phase of a packet.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      sink_tick <= sink_tick + 1;
      if (sink_mode_left == 0) begin
        sink_mode      <= $urandom_range(0, 3);
        sink_mode_left <= $urandom_range(20, 300);
      end else begin
        sink_mode_left <= sink_mode_left - 1;
      end
      case (sink_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
        2:       m_axis_tready <= (sink_tick % 4 == 0);
        default: m_axis_tready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // Watchdog: any accepted request on either stream restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte and returns at the falling edge after it was accepted. Between
  // bursts the valid drops for a random gap; within a burst it stays high.
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = 0;
      if (!sender_steady) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Drops the valid and waits until every result has come back, plus a short margin,
  // so that the limits are only written while the block is idle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (awaited != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One register write: a setup cycle, then an access cycle in which it takes effect.
  // The upper data bits carry noise, since only the low twelve bits are stored.
  task automatic write_limit(input reg_idx_e idx, input logic [LIM_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'({idx, 2'b00});
    pwdata  <= {20'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0]           opening [22];
    int unsigned          widths [NUM_PHASES];
    int unsigned          heights [NUM_PHASES];
    logic [LIM_BITS-1:0]  w;
    logic [LIM_BITS-1:0]  h;
    logic [1:0]           drift;
    logic [7:0]           b;
    int unsigned          slot;
    int unsigned          count;

    // The first byte is dropped. Then packets that walk the cursor into every clamp but
    // the X floor at the reset limits: largest positive and negative deltas, minus one,
    // zero, and flags bytes with sync and overflow bits set that must change nothing else.
    opening = '{8'h3F,
                8'h08, 8'h7F, 8'h7F,
                8'h39, 8'h00, 8'h00,
                8'hCF, 8'hFF, 8'hFF,
                8'h3A, 8'hFF, 8'hFF,
                8'h0C, 8'h80, 8'h80,
                8'h30, 8'h01, 8'h01,
                8'h00, 8'h00, 8'h00};

    // Limits per random phase: both extremes, a limit of one, a limit of zero that parks
    // the axis at 0, mixed extremes, and random values. Going from large limits to tiny
    // ones leaves a stored position above the new limit until the next delta.
    widths  = '{4095, 1, 0, 2, 640, 4095, 1, RANDOM_LIMIT, RANDOM_LIMIT, RANDOM_LIMIT, 320};
    heights = '{4095, 1, 0, 3, 480, 1, 4095, RANDOM_LIMIT, RANDOM_LIMIT, RANDOM_LIMIT, 200};

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part runs at the reset limits, so those are checked before any write.
    foreach (opening[i]) push_byte(opening[i]);
    slot = 0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      w = (widths[ph] == RANDOM_LIMIT) ? LIM_BITS'($urandom_range(1, 4095))
                                       : LIM_BITS'(widths[ph]);
      h = (heights[ph] == RANDOM_LIMIT) ? LIM_BITS'($urandom_range(1, 4095))
                                        : LIM_BITS'(heights[ph]);
      write_limit(REG_WIDTH, w);
      write_limit(REG_HEIGHT, h);
      @(negedge clk_i);

      // Every fourth phase streams without sender gaps. The drift picks whether the
      // sign bits lean positive, negative or fall evenly, so the cursor reaches both
      // ends of even the widest screen.
      sender_steady = (ph % 4 == 3);
      drift = 2'($urandom_range(0, 2));
      count = $urandom_range(150, 195);

      for (int n = 0; n < count; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: any byte at any place in the packet.
          b = 8'($urandom);
        end else if (slot == 0) begin
          b = 8'($urandom);
          if (drift != 2'd2) begin
            b[4] = ($urandom_range(0, 3) == 0) ? !drift[0] : drift[0];
            b[5] = ($urandom_range(0, 3) == 0) ? !drift[0] : drift[0];
          end
        end else if ($urandom_range(0, 9) < 3) begin
          case ($urandom_range(0, 3))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            2:       b = 8'h80;
            default: b = 8'h7F;
          endcase
        end else begin
          b = 8'($urandom);
        end
        push_byte(b);
        slot = (slot == 2) ? 0 : slot + 1;
      end
    end

    // Wait for every result, then a few cycles more in case something extra comes out.
    drain_results();
    repeat (8) @(negedge clk_i);

    if (mismatches == 0 && awaited == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
